// ===== rtl/core/dnir_pkg.sv =====
// Shared types and constants for the day/night IR-cut switch.
// Holds register indexes, field widths, the debounce limit, PWM constants, reset values and the decision struct.
// No dependencies.
package dnir_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned LEVEL_W  = 11;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned PWM_W    = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned INDEX_W  = 2;

  // Debounce: the mode flips on a qualifying sample once the count exceeds this
  localparam int unsigned TRIGGER_COUNT = 10;
  localparam int unsigned QCNT_W        = $clog2(TRIGGER_COUNT + 2);

  // PWM constants
  localparam logic [PWM_W-1:0]  PWM_PERIOD = PWM_W'(3000000 / 3000);
  localparam logic [DUTY_W-1:0] DUTY_MAX   = DUTY_W'(100);

  // Register reset values
  localparam logic [LEVEL_W-1:0] SENSITIVITY_RESET = LEVEL_W'(512);
  localparam logic [LEVEL_W-1:0] HYSTERESIS_RESET  = LEVEL_W'(64);
  localparam logic [DUTY_W-1:0]  DUTY_RESET        = DUTY_W'(100);

  // Configuration register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_HYSTERESIS  = 2'd1,
    REG_IR_DUTY     = 2'd2
  } reg_index_t;

  // Outcome of one sample against the current mode and counter
  typedef struct packed {
    logic              switched;
    logic              night_next;
    logic [QCNT_W-1:0] count_next;
  } decision_t;

endpackage

// ===== rtl/core/dnir_decide.sv =====
// Threshold compare and debounce counter update for one light sample.
// Purely combinational; uses dnir_pkg for widths and the decision struct.
module dnir_decide (
  input  logic [dnir_pkg::SAMPLE_W-1:0] light_sample,
  input  logic                          night_active,
  input  logic [dnir_pkg::QCNT_W-1:0]   qualify_count,
  input  logic [dnir_pkg::LEVEL_W-1:0]  sensitivity_level,
  input  logic [dnir_pkg::LEVEL_W-1:0]  hysteresis_level,
  output dnir_pkg::decision_t           decision
);

  logic [dnir_pkg::LEVEL_W-1:0] sample_ext;
  logic [dnir_pkg::LEVEL_W-1:0] day_threshold;
  logic                         qualifies;
  logic                         count_full;

  assign sample_ext = dnir_pkg::LEVEL_W'(light_sample);

  // Day-to-night threshold, floored at zero
  assign day_threshold = (sensitivity_level < hysteresis_level) ?
                         '0 : (sensitivity_level - hysteresis_level);

  // Day mode looks for dark samples, night mode for bright ones
  assign qualifies = night_active ? (sample_ext > sensitivity_level)
                                  : (sample_ext < day_threshold);

  assign count_full = (qualify_count > dnir_pkg::QCNT_W'(dnir_pkg::TRIGGER_COUNT));

  // Flip the mode once the counter is past the limit, else advance or clear it
  always_comb begin
    decision.switched   = 1'b0;
    decision.night_next = night_active;
    decision.count_next = '0;
    if (qualifies) begin
      if (count_full) begin
        decision.switched   = 1'b1;
        decision.night_next = ~night_active;
      end else begin
        decision.count_next = qualify_count + dnir_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/day_night_ircut_switch.sv =====
// Day/night IR-cut switch controller: top level with config registers and result register.
// Depends on dnir_pkg and dnir_decide.
//
//   channel   | valid     | stall     | payload
//   ----------+-----------+-----------+-------------------------------------------
//   input     | in_valid  | in_stall  | light_sample
//   output    | out_valid | out_stall | mode_switched, night_mode, color_filter_on,
//             |           |           | ir_pwm_enable, pwm_period_count,
//             |           |           | pwm_high_count
//   config    | cfg_write_en (no handshake) | cfg_index, cfg_data
//
// One sample per cycle while in_stall is low; its result appears in the cycle after the transfer,
// from the single compare-and-count stage ahead of the result register.
// Synchronous active-high rst returns to day mode with a clear counter and
// loads the register defaults; no clearing pass is needed.
// in_stall is high only while a result is held and out_stall is high, so a
// new sample enters in the same cycle the held result is taken.
module day_night_ircut_switch (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes
  input  logic                            cfg_write_en,
  input  logic [dnir_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [dnir_pkg::CFG_W-1:0]      cfg_data,
  // Sample input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dnir_pkg::SAMPLE_W-1:0]   light_sample,
  // Result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            mode_switched,
  output logic                            night_mode,
  output logic                            color_filter_on,
  output logic                            ir_pwm_enable,
  output logic [dnir_pkg::PWM_W-1:0]      pwm_period_count,
  output logic [dnir_pkg::PWM_W-1:0]      pwm_high_count
);

  logic [dnir_pkg::LEVEL_W-1:0] sensitivity_level;
  logic [dnir_pkg::LEVEL_W-1:0] hysteresis_level;
  logic [dnir_pkg::DUTY_W-1:0]  ir_duty_percent;
  logic                         night_active;
  logic [dnir_pkg::QCNT_W-1:0]  qualify_count;
  dnir_pkg::decision_t          decision;
  logic                         in_xfer;
  logic [dnir_pkg::DUTY_W-1:0]  duty_sat;
  logic [dnir_pkg::PWM_W-1:0]   high_count_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_level <= dnir_pkg::SENSITIVITY_RESET;
      hysteresis_level  <= dnir_pkg::HYSTERESIS_RESET;
      ir_duty_percent   <= dnir_pkg::DUTY_RESET;
    end else if (cfg_write_en) begin
      case (dnir_pkg::reg_index_t'(cfg_index))
        dnir_pkg::REG_SENSITIVITY: sensitivity_level <= cfg_data;
        dnir_pkg::REG_HYSTERESIS:  hysteresis_level  <= cfg_data;
        dnir_pkg::REG_IR_DUTY:     ir_duty_percent   <= cfg_data[dnir_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a sample whenever the result register is free or being drained
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  dnir_decide u_decide (
    .light_sample      (light_sample),
    .night_active      (night_active),
    .qualify_count     (qualify_count),
    .sensitivity_level (sensitivity_level),
    .hysteresis_level  (hysteresis_level),
    .decision          (decision)
  );

  // Saturate duty and scale by ten (period 1000 over 100 percent)
  assign duty_sat        = (ir_duty_percent > dnir_pkg::DUTY_MAX) ?
                           dnir_pkg::DUTY_MAX : ir_duty_percent;
  assign high_count_next = (dnir_pkg::PWM_W'(duty_sat) << 3)
                         + (dnir_pkg::PWM_W'(duty_sat) << 1);

  // Mode and debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      night_active  <= 1'b0;
      qualify_count <= '0;
    end else if (in_xfer) begin
      night_active  <= decision.night_next;
      qualify_count <= decision.count_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_switched    <= decision.switched;
      night_mode       <= decision.night_next;
      color_filter_on  <= ~decision.night_next;
      ir_pwm_enable    <= decision.night_next;
      pwm_period_count <= dnir_pkg::PWM_PERIOD;
      pwm_high_count   <= high_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Counter never runs past the switch point
  assert property (@(posedge clk) disable iff (rst)
    qualify_count <= dnir_pkg::QCNT_W'(dnir_pkg::TRIGGER_COUNT + 1))
    else $error("qualify_count beyond trigger limit");

  // A held result always matches the live mode
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (night_mode == night_active))
    else $error("held night_mode differs from mode state");

  // A switch result leaves the counter cleared
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode_switched) |-> (qualify_count == '0))
    else $error("counter not cleared after mode switch");

  // A mode change in the state only comes with a transfer flagged as a switch
  assert property (@(posedge clk) disable iff (rst)
    (night_active != $past(night_active)) |-> (out_valid && mode_switched))
    else $error("mode changed without a switch result");
`endif

endmodule

// ===== verif/day_night_ircut_switch_tb.sv =====
`timescale 1ns / 1ps
// Testbench for day_night_ircut_switch: sends light samples under changing register
// settings, predicts each result with its own day/night debounce model and checks it.
// Depends on dnir_pkg and the day_night_ircut_switch RTL.
module day_night_ircut_switch_tb;

  // Index 3 has no register behind it; writes there must be ignored
  localparam logic [dnir_pkg::INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS      = 148;
  localparam int N_PHASES         = 13;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic                       changed;
    logic                       night;
    logic                       filter_in;
    logic                       ir_on;
    logic [dnir_pkg::PWM_W-1:0] period;
    logic [dnir_pkg::PWM_W-1:0] high_count;
  } result_t;

  typedef struct {
    int      sample;
    int      reps;
    bit      typed;
    result_t want;
  } row_t;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          cfg_write_en = 1'b0;
  logic [dnir_pkg::INDEX_W-1:0]  cfg_index    = '0;
  logic [dnir_pkg::CFG_W-1:0]    cfg_data     = '0;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic [dnir_pkg::SAMPLE_W-1:0] light_sample = '0;
  logic                          out_valid;
  logic                          out_stall;
  logic                          mode_switched;
  logic                          night_mode;
  logic                          color_filter_on;
  logic                          ir_pwm_enable;
  logic [dnir_pkg::PWM_W-1:0]    pwm_period_count;
  logic [dnir_pkg::PWM_W-1:0]    pwm_high_count;

  // Receiver stall: random bursts plus one long hold-off
  logic rand_stall = 1'b0;
  logic long_hold  = 1'b0;
  assign out_stall = rand_stall | long_hold;

  // Idle rates in percent, changed per phase
  int in_idle_pct  = 20;
  int out_idle_pct = 20;
  bit hold_go      = 1'b0;

  // Mirror of the mode controller
  int sens_lvl  = 512;
  int hyst_lvl  = 64;
  int duty_pct  = 100;
  bit night_now = 1'b0;
  int qual_cnt  = 0;

  result_t pending_results[$];
  int      fail_count = 0;

  day_night_ircut_switch u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .light_sample     (light_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mode_switched    (mode_switched),
    .night_mode       (night_mode),
    .color_filter_on  (color_filter_on),
    .ir_pwm_enable    (ir_pwm_enable),
    .pwm_period_count (pwm_period_count),
    .pwm_high_count   (pwm_high_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Day-to-night threshold: sensitivity minus hysteresis, floored at zero
  function automatic int dark_threshold();
    return (sens_lvl < hyst_lvl) ? 0 : sens_lvl - hyst_lvl;
  endfunction

  // Advance the mode/debounce mirror by one sample and return its result
  function automatic result_t predict_mode_step(int sample);
    bit      hit;
    int      duty;
    result_t r;
    r.changed = 1'b0;
    if (!night_now) hit = sample < dark_threshold();
    else hit = sample > sens_lvl;
    if (hit) begin
      if (qual_cnt > dnir_pkg::TRIGGER_COUNT) begin
        night_now = !night_now;
        qual_cnt  = 0;
        r.changed = 1'b1;
      end else begin
        qual_cnt++;
      end
    end else begin
      qual_cnt = 0;
    end
    duty         = (duty_pct > 100) ? 100 : duty_pct;
    r.night      = night_now;
    r.filter_in  = !night_now;
    r.ir_on      = night_now;
    r.period     = dnir_pkg::PWM_W'(1000);
    r.high_count = dnir_pkg::PWM_W'(1000 * duty / 100);
    return r;
  endfunction

  // Pick a sample that counts toward a switch, or noise / a value at the threshold
  function automatic int pick_sample(bit want_hit);
    int t;
    int v;
    t = dark_threshold();
    if (want_hit) begin
      if (!night_now && t > 0) return $urandom_range(0, ((t > 1024) ? 1024 : t) - 1);
      if (night_now && sens_lvl < 1023) return $urandom_range(sens_lvl + 1, 1023);
      return $urandom_range(0, 1023);
    end
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 1023);
    v = night_now ? sens_lvl + $urandom_range(0, 1) : t - $urandom_range(0, 1);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  function automatic row_t mk_row(int sample, int reps, bit typed, bit sw, bit nt);
    row_t r;
    r.sample = sample;
    r.reps   = reps;
    r.typed  = typed;
    r.want   = {sw, nt, ~nt, nt, dnir_pkg::PWM_W'(1000), dnir_pkg::PWM_W'(1000)};
    return r;
  endfunction

  // Write one register while the block is idle; keep the mirror in step
  task automatic write_reg(logic [dnir_pkg::INDEX_W-1:0] idx,
                           logic [dnir_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      dnir_pkg::REG_SENSITIVITY: sens_lvl = data;
      dnir_pkg::REG_HYSTERESIS:  hyst_lvl = data;
      dnir_pkg::REG_IR_DUTY:     duty_pct = data[dnir_pkg::DUTY_W-1:0];
      default: ;  // unmapped index: no effect
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Offer one sample, hold it until the transfer, then record the expected result
  task automatic send_sample(int sample, bit typed, result_t want);
    result_t predicted;
    @(negedge clk);
    in_valid     <= 1'b1;
    light_sample <= dnir_pkg::SAMPLE_W'(sample);
    do @(posedge clk); while (in_stall);
    predicted = predict_mode_step(sample);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Random sender gap with in_valid low, taken with chance in_idle_pct
  task automatic maybe_pause();
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Random receiver stall bursts, started with chance out_idle_pct
  always @(negedge clk) begin : stall_driver
    static int stall_left = 0;
    if (stall_left > 0) begin
      stall_left--;
      rand_stall <= 1'b1;
    end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(0, 10);
      rand_stall <= 1'b1;
    end else begin
      rand_stall <= 1'b0;
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (hold_go);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t got;
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      got = {mode_switched, night_mode, color_filter_on, ir_pwm_enable,
             pwm_period_count, pwm_high_count};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: sw=%0b night=%0b filt=%0b ir=%0b per=%0d hi=%0d",
                   got.changed, got.night, got.filter_in, got.ir_on, got.period,
                   got.high_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"mismatch: exp sw=%0b night=%0b filt=%0b ir=%0b per=%0d hi=%0d,",
                      " got sw=%0b night=%0b filt=%0b ir=%0b per=%0d hi=%0d"},
                     exp_r.changed, exp_r.night, exp_r.filter_in, exp_r.ir_on,
                     exp_r.period, exp_r.high_count, got.changed, got.night,
                     got.filter_in, got.ir_on, got.period, got.high_count);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t    rows[7];
    result_t none;
    int      n;
    int      run;
    bit      hit;
    int      s_val;
    int      h_val;
    int      d_val;

    none = '0;
    // Directed sequence at the reset settings (dark threshold 448, bright 512)
    rows[0] = mk_row(1023,  1, 1'b1, 1'b0, 1'b0);  // brightest right after reset
    rows[1] = mk_row(448,   1, 1'b0, 1'b0, 1'b0);  // exactly at the dark threshold
    rows[2] = mk_row(0,    11, 1'b0, 1'b0, 1'b0);  // darkest, counting up
    rows[3] = mk_row(447,   1, 1'b1, 1'b1, 1'b1);  // twelfth dark sample: to night
    rows[4] = mk_row(512,   1, 1'b0, 1'b0, 1'b0);  // equal to sensitivity: no count
    rows[5] = mk_row(513,  11, 1'b0, 1'b0, 1'b0);
    rows[6] = mk_row(1023,  1, 1'b1, 1'b1, 1'b0);  // twelfth bright sample: to day

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      repeat (rows[i].reps) begin
        send_sample(rows[i].sample, rows[i].typed, rows[i].want);
        maybe_pause();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Random phases, each under its own register setting
    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin s_val = 0;     h_val = 0;     d_val = 0;               end
        1: begin s_val = 1023;  h_val = 0;     d_val = 100;             end
        2: begin s_val = 1024;  h_val = 1024;  d_val = 11'h7ff;         end
        3: begin s_val = 300;   h_val = 500;   d_val = 1;               end
        4: begin s_val = 2047;  h_val = 2047;  d_val = 64;              end
        5: begin s_val = 600;   h_val = 100;   d_val = 11'h400 | 55;    end
        6: begin s_val = 1;     h_val = 0;     d_val = 99;              end
        default: begin
          s_val = $urandom_range(0, 1024);
          h_val = $urandom_range(0, 400);
          d_val = $urandom_range(0, 127) | ($urandom_range(0, 15) << dnir_pkg::DUTY_W);
        end
      endcase
      write_reg(dnir_pkg::REG_SENSITIVITY, dnir_pkg::CFG_W'(s_val));
      write_reg(dnir_pkg::REG_HYSTERESIS, dnir_pkg::CFG_W'(h_val));
      write_reg(dnir_pkg::REG_IR_DUTY, dnir_pkg::CFG_W'(d_val));
      write_reg(REG_SPARE, dnir_pkg::CFG_W'($urandom_range(0, 2047)));

      // No idling in the final phase
      case ($urandom_range(0, 2))
        0: in_idle_pct = 0;
        1: in_idle_pct = 15;
        default: in_idle_pct = 35;
      endcase
      out_idle_pct = (phase == N_PHASES - 1) ? 0 : $urandom_range(0, 35);
      if (phase == N_PHASES - 1) in_idle_pct = 0;

      // Mostly runs of qualifying samples, with noise between them
      n = 0;
      while (n < PHASE_ITEMS) begin
        hit = ($urandom_range(0, 9) < 7);
        run = hit ? $urandom_range(4, 16) : 1;
        for (int k = 0; k < run && n < PHASE_ITEMS; k++) begin
          if (phase == 2 && n == 40) hold_go = 1'b1;
          send_sample(pick_sample(hit), 1'b0, none);
          n++;
          maybe_pause();
        end
      end
      @(negedge clk);
      in_valid <= 1'b0;
    end

    drain_results();
    repeat (4) @(negedge clk);
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dnir_pkg.sv
rtl/core/dnir_decide.sv
rtl/core/day_night_ircut_switch.sv
verif/day_night_ircut_switch_tb.sv
